>>> sv/gbuf_pkg.sv
// Shared types and constants for the gap-buffer text store.
`timescale 1ns / 1ps
package gbuf_pkg;

  // Document geometry
  localparam int DocSize = 4096;
  localparam int AddrW   = $clog2(DocSize);
  localparam int PtrW    = $clog2(DocSize + 1);
  localparam int CmpW    = (PtrW > 12) ? PtrW : 12;

  // Field widths fixed by the interface
  localparam int OpW     = 3;
  localparam int CharW   = 8;
  localparam int IdxW    = 12;
  localparam int CountW  = 13;
  localparam int StatW   = 2;

  // Command queue between front and back
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam int QCntW   = 2;

  localparam logic [CharW-1:0] NewlineByte = 8'h0A;

  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 3'd0,
    OP_BACKSPACE = 3'd1,
    OP_LEFT      = 3'd2,
    OP_RIGHT     = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_READ      = 3'd5,
    OP_BAD       = 3'd6
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_BEYOND  = 2'd2
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_FIN
  } back_state_e;

  // One classified command as it travels through the queue
  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] ch;
    logic [IdxW-1:0]  idx;
  } cmd_t;

endpackage

>>> sv/gap_buffer_text_store.sv
// Top level of the gap-buffer text store: front end, command queue and back end.
//
//  channel   signals                                       direction  handshake
//  command   start_i, opcode_i, char_code_i, read_index_i  in         start_i && !busy_o
//  result    done_o, char_out_o, text_length_o,            out        done_o, one cycle
//            cursor_pos_o, status_o
//
// Insert, backspace, ignored and out-of-range commands finish in the back end's idle state;
// cursor moves, overwrite with a byte after the gap, and reads also pass through its finish
// state, for the registered read of the single text memory before its write.
// The result appears the cycle after the back end finishes; a two-entry command queue
// lets the front accept up to two commands ahead, so busy_o rises only when it fills.
// Reset empties the queue, places the cursor at 0 and the gap end at the memory end;
// the text memory is not cleared. The receiver cannot stall results.
`timescale 1ns / 1ps
module gap_buffer_text_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [gbuf_pkg::OpW-1:0]         opcode_i,
  input  logic [gbuf_pkg::CharW-1:0]       char_code_i,
  input  logic [gbuf_pkg::IdxW-1:0]        read_index_i,
  output logic                             done_o,
  output logic [gbuf_pkg::CharW-1:0]       char_out_o,
  output logic [gbuf_pkg::CountW-1:0]      text_length_o,
  output logic [gbuf_pkg::CountW-1:0]      cursor_pos_o,
  output logic [gbuf_pkg::StatW-1:0]       status_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  gbuf_pkg::cmd_t cmd;

  gbuf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .opcode_i     (opcode_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  gbuf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .done_o        (done_o),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

endmodule

>>> sv/gbuf_front.sv
// Front end: takes commands, classifies the opcode and queues them for the back end.
`timescale 1ns / 1ps
module gbuf_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [gbuf_pkg::OpW-1:0]       opcode_i,
  input  logic [gbuf_pkg::CharW-1:0]     char_code_i,
  input  logic [gbuf_pkg::IdxW-1:0]      read_index_i,
  output logic                           cmd_valid_o,
  output gbuf_pkg::cmd_t                 cmd_o,
  input  logic                           cmd_pop_i
);

  gbuf_pkg::cmd_t             q_mem [gbuf_pkg::QDepth];
  logic [gbuf_pkg::QPtrW-1:0] wptr_q, wptr_d;
  logic [gbuf_pkg::QPtrW-1:0] rptr_q, rptr_d;
  logic [gbuf_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       push, pop, full, empty;
  gbuf_pkg::cmd_t             cls;

  // Classify: unknown opcodes collapse onto one code
  always_comb begin
    cls.ch  = char_code_i;
    cls.idx = read_index_i;
    case (opcode_i)
      gbuf_pkg::OP_INSERT:    cls.op = gbuf_pkg::OP_INSERT;
      gbuf_pkg::OP_BACKSPACE: cls.op = gbuf_pkg::OP_BACKSPACE;
      gbuf_pkg::OP_LEFT:      cls.op = gbuf_pkg::OP_LEFT;
      gbuf_pkg::OP_RIGHT:     cls.op = gbuf_pkg::OP_RIGHT;
      gbuf_pkg::OP_OVERWRITE: cls.op = gbuf_pkg::OP_OVERWRITE;
      gbuf_pkg::OP_READ:      cls.op = gbuf_pkg::OP_READ;
      default:                cls.op = gbuf_pkg::OP_BAD;
    endcase
  end

  // Queue control
  assign full        = (cnt_q == gbuf_pkg::QCntW'(gbuf_pkg::QDepth));
  assign empty       = (cnt_q == '0);
  assign busy_o      = full;
  assign push        = start_i && !full;
  assign pop         = cmd_pop_i && !empty;
  assign cmd_valid_o = !empty;
  assign cmd_o       = q_mem[rptr_q];

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop  ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cls;
    end
  end

  // Occupancy never exceeds the queue depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= gbuf_pkg::QCntW'(gbuf_pkg::QDepth))
    else $error("command queue overfilled");

  // Pointer distance, taken at pointer width, matches the occupancy count when not full
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (gbuf_pkg::QCntW'(gbuf_pkg::QPtrW'(wptr_q - rptr_q)) == cnt_q))
    else $error("queue pointers disagree with count");

endmodule

>>> sv/gbuf_back.sv
// Back end: owns the text memory and gap pointers, executes commands and emits results.
`timescale 1ns / 1ps
module gbuf_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  gbuf_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             done_o,
  output logic [gbuf_pkg::CharW-1:0]       char_out_o,
  output logic [gbuf_pkg::CountW-1:0]      text_length_o,
  output logic [gbuf_pkg::CountW-1:0]      cursor_pos_o,
  output logic [gbuf_pkg::StatW-1:0]       status_o
);

  localparam logic [gbuf_pkg::PtrW-1:0] DocEnd = gbuf_pkg::PtrW'(gbuf_pkg::DocSize);

  // Text memory, one write and one registered read per cycle
  logic [gbuf_pkg::CharW-1:0] mem [gbuf_pkg::DocSize];
  logic                       we, re;
  logic [gbuf_pkg::AddrW-1:0] waddr, raddr;
  logic [gbuf_pkg::CharW-1:0] wdata, rdata_q;

  gbuf_pkg::back_state_e      state_q, state_d;
  gbuf_pkg::cmd_t             pend_q, pend_d;
  logic [gbuf_pkg::PtrW-1:0]  gs_q, gs_d, ge_q, ge_d;
  logic [gbuf_pkg::PtrW-1:0]  len_cur, len_d;

  logic                       done_q, done_d;
  logic [gbuf_pkg::CharW-1:0] char_q, char_d;
  logic [gbuf_pkg::CountW-1:0] len_q, cur_q;
  gbuf_pkg::status_e          stat_q, stat_d;

  logic                       full, at_start, at_end;
  logic [gbuf_pkg::CmpW-1:0]  idx_x, len_x, phys;

  assign full     = (gs_q == ge_q);
  assign at_start = (gs_q == '0);
  assign at_end   = (ge_q == DocEnd);
  assign len_cur  = gs_q + (DocEnd - ge_q);
  assign len_d    = gs_d + (DocEnd - ge_d);

  // Logical to physical index for a read, skipping the gap for an index past it
  assign idx_x = gbuf_pkg::CmpW'(cmd_i.idx);
  assign len_x = gbuf_pkg::CmpW'(len_cur);
  assign phys  = (idx_x < gbuf_pkg::CmpW'(gs_q)) ? idx_x
               : idx_x + gbuf_pkg::CmpW'(ge_q) - gbuf_pkg::CmpW'(gs_q);

  // Sequencer: start a command, and finish it after the memory read if it needs one
  always_comb begin
    state_d   = state_q;
    pend_d    = pend_q;
    gs_d      = gs_q;
    ge_d      = ge_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = gs_q[gbuf_pkg::AddrW-1:0];
    wdata     = cmd_i.ch;
    re        = 1'b0;
    raddr     = ge_q[gbuf_pkg::AddrW-1:0];
    done_d    = 1'b0;
    char_d    = '0;
    stat_d    = gbuf_pkg::ST_DONE;

    case (state_q)
      gbuf_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          pend_d    = cmd_i;
          done_d    = 1'b1;
          case (cmd_i.op)
            gbuf_pkg::OP_INSERT: begin
              if (full) begin
                stat_d = gbuf_pkg::ST_IGNORED;
              end else begin
                we   = 1'b1;
                gs_d = gs_q + 1'b1;
              end
            end
            gbuf_pkg::OP_BACKSPACE: begin
              if (at_start) begin
                stat_d = gbuf_pkg::ST_IGNORED;
              end else begin
                gs_d = gs_q - 1'b1;
              end
            end
            gbuf_pkg::OP_LEFT: begin
              if (at_start) begin
                stat_d = gbuf_pkg::ST_IGNORED;
              end else begin
                re      = 1'b1;
                raddr   = gbuf_pkg::AddrW'(gs_q - 1'b1);
                done_d  = 1'b0;
                state_d = gbuf_pkg::BK_FIN;
              end
            end
            gbuf_pkg::OP_RIGHT: begin
              if (at_end) begin
                stat_d = gbuf_pkg::ST_IGNORED;
              end else begin
                re      = 1'b1;
                done_d  = 1'b0;
                state_d = gbuf_pkg::BK_FIN;
              end
            end
            gbuf_pkg::OP_OVERWRITE: begin
              if (full) begin
                stat_d = gbuf_pkg::ST_IGNORED;
              end else begin
                we = 1'b1;
                if (at_end) begin
                  gs_d = gs_q + 1'b1;
                end else begin
                  // fetch the byte after the gap to decide whether to absorb it
                  re      = 1'b1;
                  done_d  = 1'b0;
                  state_d = gbuf_pkg::BK_FIN;
                end
              end
            end
            gbuf_pkg::OP_READ: begin
              if (idx_x >= len_x) begin
                stat_d = gbuf_pkg::ST_BEYOND;
              end else begin
                re      = 1'b1;
                raddr   = phys[gbuf_pkg::AddrW-1:0];
                done_d  = 1'b0;
                state_d = gbuf_pkg::BK_FIN;
              end
            end
            default: begin
              stat_d = gbuf_pkg::ST_IGNORED;
            end
          endcase
        end
      end

      gbuf_pkg::BK_FIN: begin
        done_d  = 1'b1;
        state_d = gbuf_pkg::BK_IDLE;
        wdata   = rdata_q;
        case (pend_q.op)
          gbuf_pkg::OP_LEFT: begin
            we    = 1'b1;
            waddr = gbuf_pkg::AddrW'(ge_q - 1'b1);
            gs_d  = gs_q - 1'b1;
            ge_d  = ge_q - 1'b1;
          end
          gbuf_pkg::OP_RIGHT: begin
            we   = 1'b1;
            gs_d = gs_q + 1'b1;
            ge_d = ge_q + 1'b1;
          end
          gbuf_pkg::OP_OVERWRITE: begin
            gs_d = gs_q + 1'b1;
            if (rdata_q != gbuf_pkg::NewlineByte) begin
              ge_d = ge_q + 1'b1;
            end
          end
          gbuf_pkg::OP_READ: begin
            char_d = rdata_q;
          end
          default: begin
            stat_d = gbuf_pkg::ST_IGNORED;
          end
        endcase
      end

      default: begin
        state_d = gbuf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbuf_pkg::BK_IDLE;
      gs_q    <= '0;
      ge_q    <= DocEnd;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      ge_q    <= ge_d;
      done_q  <= done_d;
    end
  end

  // Result and pending-command payload
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (done_d) begin
      char_q <= char_d;
      stat_q <= stat_d;
      len_q  <= gbuf_pkg::CountW'(len_d);
      cur_q  <= gbuf_pkg::CountW'(gs_d);
    end
  end

  // Text memory ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign done_o        = done_q;
  assign char_out_o    = char_q;
  assign text_length_o = len_q;
  assign cursor_pos_o  = cur_q;
  assign status_o      = stat_q;

  // The gap never inverts and never runs past the end of the memory
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gs_q <= ge_q) && (ge_q <= DocEnd))
    else $error("gap pointers out of order");

  // A command parked for its memory read reports in the following cycle
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbuf_pkg::BK_FIN) |=> done_q)
    else $error("two-cycle command produced no result");

  // Nothing is popped while a command is still finishing
  a_no_pop_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbuf_pkg::BK_FIN) |-> !cmd_pop_o)
    else $error("queue popped during finish cycle");

endmodule

>>> bench/gap_buffer_text_store_tb.sv
// Self-checking testbench for the gap-buffer text store: directed edits and random edits.
`timescale 1ns / 1ps
module gap_buffer_text_store_tb;

  localparam logic [gbuf_pkg::OpW-1:0] OpUnused = 3'd7;  // second opcode with no operation
  localparam int RandomItems = 1310;
  localparam int TailItems   = 200;
  localparam int StallLimit  = 1000;  // cycles with no transaction on either side
  localparam int DrainCycles = 16;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [gbuf_pkg::OpW-1:0]      opcode_i;
  logic [gbuf_pkg::CharW-1:0]    char_code_i;
  logic [gbuf_pkg::IdxW-1:0]     read_index_i;
  logic                          done_o;
  logic [gbuf_pkg::CharW-1:0]    char_out_o;
  logic [gbuf_pkg::CountW-1:0]   text_length_o;
  logic [gbuf_pkg::CountW-1:0]   cursor_pos_o;
  logic [gbuf_pkg::StatW-1:0]    status_o;

  // Expected outcome of one edit or read
  typedef struct {
    logic [gbuf_pkg::CharW-1:0]  ch;
    logic [gbuf_pkg::CountW-1:0] len;
    logic [gbuf_pkg::CountW-1:0] cur;
    logic [gbuf_pkg::StatW-1:0]  st;
  } edit_result_t;

  // Mirror of the text store plus the queue of results still owed by the block
  class text_scoreboard;
    bit [gbuf_pkg::CharW-1:0] text_mem [gbuf_pkg::DocSize];
    int             cursor;
    int             gap_end;
    edit_result_t   owed_q[$];
    int             errors;
    int             checked;
    int             op_seen[8];

    function new();
      cursor    = 0;
      gap_end   = gbuf_pkg::DocSize;
      errors    = 0;
      checked   = 0;
    endfunction

    function int text_len();
      return cursor + (gbuf_pkg::DocSize - gap_end);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Apply one accepted command to the mirror and queue its result
    function void note_command(logic [gbuf_pkg::OpW-1:0] op, logic [gbuf_pkg::CharW-1:0] ch,
                               logic [gbuf_pkg::IdxW-1:0] idx);
      edit_result_t r;
      int phys;
      r.ch = '0;
      r.st = gbuf_pkg::ST_DONE;
      op_seen[op]++;
      case (op)
        gbuf_pkg::OP_INSERT: begin
          if (cursor >= gap_end) r.st = gbuf_pkg::ST_IGNORED;
          else begin
            text_mem[cursor] = ch;
            cursor++;
          end
        end
        gbuf_pkg::OP_BACKSPACE: begin
          if (cursor == 0) r.st = gbuf_pkg::ST_IGNORED;
          else cursor--;
        end
        gbuf_pkg::OP_LEFT: begin
          if (cursor == 0) r.st = gbuf_pkg::ST_IGNORED;
          else begin
            cursor--;
            gap_end--;
            text_mem[gap_end] = text_mem[cursor];
          end
        end
        gbuf_pkg::OP_RIGHT: begin
          if (gap_end >= gbuf_pkg::DocSize) r.st = gbuf_pkg::ST_IGNORED;
          else begin
            text_mem[cursor] = text_mem[gap_end];
            cursor++;
            gap_end++;
          end
        end
        gbuf_pkg::OP_OVERWRITE: begin
          if (cursor >= gap_end) r.st = gbuf_pkg::ST_IGNORED;
          else begin
            text_mem[cursor] = ch;
            cursor++;
            // swallow the next byte unless it ends a line or there is none
            if (gap_end < gbuf_pkg::DocSize && text_mem[gap_end] != gbuf_pkg::NewlineByte)
              gap_end++;
          end
        end
        gbuf_pkg::OP_READ: begin
          if (int'(idx) >= text_len()) r.st = gbuf_pkg::ST_BEYOND;
          else if (int'(idx) < cursor) r.ch = text_mem[idx];
          else begin
            phys = int'(idx) + (gap_end - cursor);
            if (phys < gbuf_pkg::DocSize) r.ch = text_mem[phys];
          end
        end
        default: r.st = gbuf_pkg::ST_IGNORED;
      endcase
      r.len = gbuf_pkg::CountW'(text_len());
      r.cur = gbuf_pkg::CountW'(cursor);
      owed_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [gbuf_pkg::CountW-1:0] exp_v,
                                logic [gbuf_pkg::CountW-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // Compare one result against the oldest owed one
    function void check_result(logic [gbuf_pkg::CharW-1:0] ch, logic [gbuf_pkg::CountW-1:0] len,
                               logic [gbuf_pkg::CountW-1:0] cur, logic [gbuf_pkg::StatW-1:0] st);
      edit_result_t r;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, %s %0d %0d %0d %0d",
                 $time, "got char/len/cur/st", ch, len, cur, st);
        return;
      end
      r = owed_q.pop_front();
      checked++;
      compare_field("char_out", gbuf_pkg::CountW'(r.ch), gbuf_pkg::CountW'(ch));
      compare_field("text_length", r.len, len);
      compare_field("cursor_pos", r.cur, cur);
      compare_field("status", gbuf_pkg::CountW'(r.st), gbuf_pkg::CountW'(st));
    endfunction
  endclass

  text_scoreboard sb = new();
  int stall_cnt;

  gap_buffer_text_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .char_code_i   (char_code_i),
    .read_index_i  (read_index_i),
    .done_o        (done_o),
    .char_out_o    (char_out_o),
    .text_length_o (text_length_o),
    .cursor_pos_o  (cursor_pos_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Monitor: results first, since a result never belongs to the command taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(char_out_o, text_length_o, cursor_pos_o, status_o);
      if (start_i && !busy_o) sb.note_command(opcode_i, char_code_i, read_index_i);
      if (done_o || (start_i && !busy_o)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Drive one command; called just after a falling edge, returns on the accepting edge
  task automatic send_cmd(input logic [gbuf_pkg::OpW-1:0] op,
                          input logic [gbuf_pkg::CharW-1:0] ch,
                          input logic [gbuf_pkg::IdxW-1:0] idx);
    start_i      <= 1'b1;
    opcode_i     <= op;
    char_code_i  <= ch;
    read_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  task automatic put(input logic [gbuf_pkg::OpW-1:0] op, input logic [gbuf_pkg::CharW-1:0] ch,
                     input logic [gbuf_pkg::IdxW-1:0] idx);
    @(negedge clk_i);
    send_cmd(op, ch, idx);
  endtask

  // Sender gap with junk on the payload
  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i      <= 1'b0;
      opcode_i     <= gbuf_pkg::OpW'($urandom);
      char_code_i  <= gbuf_pkg::CharW'($urandom);
      read_index_i <= gbuf_pkg::IdxW'($urandom);
    end
  endtask

  task automatic sweep(input logic [gbuf_pkg::OpW-1:0] op, input int n);
    repeat (n) put(op, gbuf_pkg::CharW'($urandom), gbuf_pkg::IdxW'($urandom));
  endtask

  // One random command, shaped by the current text length
  task automatic random_step();
    int len;
    int r;
    int top;
    logic [gbuf_pkg::OpW-1:0]   op;
    logic [gbuf_pkg::CharW-1:0] ch;
    logic [gbuf_pkg::IdxW-1:0]  idx;
    @(negedge clk_i);
    len = sb.text_len();
    top = (len > 4095) ? 4095 : len;
    r = $urandom_range(0, 99);
    if (r < 30)      op = gbuf_pkg::OP_INSERT;
    else if (r < 40) op = gbuf_pkg::OP_BACKSPACE;
    else if (r < 54) op = gbuf_pkg::OP_LEFT;
    else if (r < 68) op = gbuf_pkg::OP_RIGHT;
    else if (r < 82) op = gbuf_pkg::OP_OVERWRITE;
    else if (r < 97) op = gbuf_pkg::OP_READ;
    else if (r < 99) op = gbuf_pkg::OP_BAD;
    else             op = OpUnused;
    ch = ($urandom_range(0, 5) == 0) ? gbuf_pkg::NewlineByte : gbuf_pkg::CharW'($urandom);
    r = $urandom_range(0, 9);
    if (r < 8)       idx = gbuf_pkg::IdxW'($urandom_range(0, top));
    else if (r == 8) idx = gbuf_pkg::IdxW'((len > 0) ? ((len - 1 > 4095) ? 4095 : len - 1) : 0);
    else             idx = gbuf_pkg::IdxW'($urandom);
    send_cmd(op, ch, idx);
  endtask

  initial begin
    int items;
    int idle_pct;
    int next_mix;
    int n;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    opcode_i     = '0;
    char_code_i  = '0;
    read_index_i = '0;
    stall_cnt    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-buffer edges, unused opcodes, overwrite at end and before a newline
    put(gbuf_pkg::OP_READ, 8'h00, 12'h000);
    put(gbuf_pkg::OP_READ, 8'hFF, 12'hFFF);
    put(gbuf_pkg::OP_BACKSPACE, 8'h00, 12'h000);
    put(gbuf_pkg::OP_LEFT, 8'hFF, 12'hFFF);
    put(gbuf_pkg::OP_RIGHT, 8'h00, 12'h000);
    put(gbuf_pkg::OP_BAD, 8'hFF, 12'hFFF);
    put(OpUnused, 8'h00, 12'h000);
    put(gbuf_pkg::OP_OVERWRITE, 8'h41, 12'h000);
    put(gbuf_pkg::OP_INSERT, 8'h00, 12'h000);
    put(gbuf_pkg::OP_INSERT, 8'hFF, 12'h000);
    put(gbuf_pkg::OP_INSERT, gbuf_pkg::NewlineByte, 12'h000);
    put(gbuf_pkg::OP_INSERT, 8'h62, 12'h000);
    sweep(gbuf_pkg::OP_LEFT, 2);
    put(gbuf_pkg::OP_OVERWRITE, 8'h55, 12'h000);
    put(gbuf_pkg::OP_RIGHT, 8'h00, 12'h000);
    put(gbuf_pkg::OP_OVERWRITE, 8'hAA, 12'h000);
    put(gbuf_pkg::OP_LEFT, 8'h00, 12'h000);
    put(gbuf_pkg::OP_READ, 8'h00, 12'd0);
    put(gbuf_pkg::OP_READ, 8'h00, 12'd5);
    put(gbuf_pkg::OP_READ, 8'h00, 12'd6);
    put(gbuf_pkg::OP_READ, 8'h00, 12'd4);
    put(gbuf_pkg::OP_BACKSPACE, 8'h00, 12'h000);
    put(gbuf_pkg::OP_READ, 8'h00, 12'd4);
    put(gbuf_pkg::OP_READ, 8'h00, 12'hAAA);

    // Random edits with sender gaps; the gap rate is drawn anew every 64 commands
    items = 0;
    idle_pct = 0;
    next_mix = 0;
    while (items < RandomItems) begin
      if (items >= next_mix) begin
        next_mix += 64;
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 25;
          default: idle_pct = 60;
        endcase
      end
      if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 5));
      if ($urandom_range(0, 99) < 3) begin
        // run the cursor toward one end of the text
        n = $urandom_range(1, 40);
        sweep(($urandom_range(0, 1) == 0) ? gbuf_pkg::OP_LEFT : gbuf_pkg::OP_RIGHT, n);
        items += n;
      end else begin
        random_step();
        items++;
      end
    end

    // Last part, back to back: edits at the cursor, reads at low and high indices, then random steps
    put(gbuf_pkg::OP_INSERT, 8'hFF, 12'h000);
    put(gbuf_pkg::OP_OVERWRITE, 8'h00, 12'hFFF);
    put(gbuf_pkg::OP_READ, 8'h00, 12'hFFF);
    put(gbuf_pkg::OP_READ, 8'h00, 12'h000);
    put(gbuf_pkg::OP_READ, 8'h00, 12'h800);
    sweep(gbuf_pkg::OP_LEFT, 3);
    put(gbuf_pkg::OP_READ, 8'h00, 12'hFFE);
    put(gbuf_pkg::OP_OVERWRITE, 8'h33, 12'h000);
    put(gbuf_pkg::OP_RIGHT, 8'h00, 12'h000);
    put(gbuf_pkg::OP_BACKSPACE, 8'h00, 12'h000);
    put(gbuf_pkg::OP_OVERWRITE, 8'hCC, 12'h000);
    put(gbuf_pkg::OP_READ, 8'h00, 12'hFFF);
    repeat (TailItems) random_step();

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d backspaces, %0d cursor moves,",
             sb.checked, sb.op_seen[gbuf_pkg::OP_INSERT], sb.op_seen[gbuf_pkg::OP_BACKSPACE],
             sb.op_seen[gbuf_pkg::OP_LEFT] + sb.op_seen[gbuf_pkg::OP_RIGHT]);
    $display("%0d overwrites, %0d reads, %0d unused opcodes, with sender gaps and full-rate runs.",
             sb.op_seen[gbuf_pkg::OP_OVERWRITE], sb.op_seen[gbuf_pkg::OP_READ],
             sb.op_seen[gbuf_pkg::OP_BAD] + sb.op_seen[OpUnused]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
